// ===== hdl/srs1f_pkg.sv =====
// Shared types, constants and the microcode table of the S19 line framer.
package srs1f_pkg;

  // Line geometry
  localparam int LineBytes = 16;
  localparam int FillW     = $clog2(LineBytes + 1);
  localparam int IdxW      = (LineBytes > 1) ? $clog2(LineBytes) : 1;
  localparam int ItemBytes = 7;
  localparam int ItemW     = $clog2(ItemBytes + 1);
  localparam int PcW       = 5;
  localparam int PaddrW    = 3;

  // Command codes
  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_APPEND = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_END    = 2'd3
  } op_e;

  // Register indexes
  localparam logic RegStartAddr = 1'b0;

  // ASCII characters
  localparam logic [6:0] ChS  = 7'h53;
  localparam logic [6:0] Ch0  = 7'h30;
  localparam logic [6:0] Ch1  = 7'h31;
  localparam logic [6:0] Ch3  = 7'h33;
  localparam logic [6:0] Ch9  = 7'h39;
  localparam logic [6:0] ChF  = 7'h46;
  localparam logic [6:0] ChC  = 7'h43;
  localparam logic [6:0] ChNl = 7'h0A;

  // Character source of a step
  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_CONST,
    OUT_TAG,
    OUT_HI,
    OUT_LO
  } out_sel_e;

  // Byte register load of a step
  typedef enum logic [2:0] {
    LD_NONE,
    LD_CNT,
    LD_AHI,
    LD_ALO,
    LD_BUF_CSUM
  } ld_sel_e;

  // Step sequencing
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_MORE,
    JMP_DISPATCH,
    JMP_PUSH,
    JMP_RET
  } jmp_e;

  typedef struct packed {
    out_sel_e       out_sel;
    logic [6:0]     chr;
    ld_sel_e        ld_sel;
    jmp_e           jmp;
    logic [PcW-1:0] target;
    logic           last;
    logic           line_end;
  } ctrl_t;

  // Step addresses
  localparam logic [PcW-1:0] PC_IDLE  = 5'd0;
  localparam logic [PcW-1:0] PC_PUSH  = 5'd1;
  localparam logic [PcW-1:0] PC_TEXT  = 5'd2;
  localparam logic [PcW-1:0] PC_LINE  = 5'd13;
  localparam logic [PcW-1:0] PC_DHI   = 5'd21;
  localparam logic [PcW-1:0] PC_LEND  = 5'd25;

  function automatic logic [6:0] hex_char(input logic [3:0] v);
    logic [6:0] c;
    if (v < 4'd10) begin
      c = 7'h30 + {3'b000, v};
    end else begin
      c = 7'h37 + {3'b000, v};
    end
    return c;
  endfunction

  function automatic ctrl_t mk_cw(input out_sel_e o, input logic [6:0] c, input ld_sel_e l,
                                  input jmp_e j, input logic [PcW-1:0] t,
                                  input logic lst, input logic le);
    ctrl_t w;
    w.out_sel  = o;
    w.chr      = c;
    w.ld_sel   = l;
    w.jmp      = j;
    w.target   = t;
    w.last     = lst;
    w.line_end = le;
    return w;
  endfunction

  // Microcode table: one control word per step
  function automatic ctrl_t srs1f_rom(input logic [PcW-1:0] pc);
    ctrl_t w;
    w = mk_cw(OUT_NONE, 7'h00, LD_NONE, JMP_DISPATCH, PC_IDLE, 1'b0, 1'b0);
    case (pc)
      5'd0:  w = mk_cw(OUT_NONE,  7'h00, LD_NONE, JMP_DISPATCH, PC_IDLE, 1'b0, 1'b0);
      5'd1:  w = mk_cw(OUT_NONE,  7'h00, LD_NONE, JMP_PUSH,     PC_IDLE, 1'b0, 1'b0);
      // header and trailer text: S, tag, 030000FC, newline
      5'd2:  w = mk_cw(OUT_CONST, ChS,   LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd3:  w = mk_cw(OUT_TAG,   7'h00, LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd4:  w = mk_cw(OUT_CONST, Ch0,   LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd5:  w = mk_cw(OUT_CONST, Ch3,   LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd6:  w = mk_cw(OUT_CONST, Ch0,   LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd7:  w = mk_cw(OUT_CONST, Ch0,   LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd8:  w = mk_cw(OUT_CONST, Ch0,   LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd9:  w = mk_cw(OUT_CONST, Ch0,   LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd10: w = mk_cw(OUT_CONST, ChF,   LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd11: w = mk_cw(OUT_CONST, ChC,   LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd12: w = mk_cw(OUT_CONST, ChNl,  LD_NONE, JMP_GOTO,     PC_IDLE, 1'b1, 1'b0);
      // S1 data line
      5'd13: w = mk_cw(OUT_CONST, ChS,   LD_CNT,  JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd14: w = mk_cw(OUT_CONST, Ch1,   LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd15: w = mk_cw(OUT_HI,    7'h00, LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd16: w = mk_cw(OUT_LO,    7'h00, LD_AHI,  JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd17: w = mk_cw(OUT_HI,    7'h00, LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd18: w = mk_cw(OUT_LO,    7'h00, LD_ALO,  JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd19: w = mk_cw(OUT_HI,    7'h00, LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd20: w = mk_cw(OUT_LO,    7'h00, LD_BUF_CSUM, JMP_NEXT, PC_IDLE, 1'b0, 1'b0);
      5'd21: w = mk_cw(OUT_HI,    7'h00, LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd22: w = mk_cw(OUT_LO,    7'h00, LD_BUF_CSUM, JMP_MORE, PC_DHI,  1'b0, 1'b0);
      5'd23: w = mk_cw(OUT_HI,    7'h00, LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd24: w = mk_cw(OUT_LO,    7'h00, LD_NONE, JMP_NEXT,     PC_IDLE, 1'b0, 1'b0);
      5'd25: w = mk_cw(OUT_CONST, ChNl,  LD_NONE, JMP_RET,      PC_IDLE, 1'b1, 1'b1);
      default: w = mk_cw(OUT_NONE, 7'h00, LD_NONE, JMP_GOTO,    PC_IDLE, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/srs1f_in_if.sv =====
// Command channel carrying one framer command and its instruction bytes.
interface srs1f_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] opcode_count;
  logic [7:0] opcode_byte1;
  logic [7:0] opcode_byte2;
  logic [2:0] data_count;
  logic [7:0] data_byte1;
  logic [7:0] data_byte2;
  logic [7:0] data_byte3;
  logic [7:0] data_byte4;
  logic [7:0] data_byte5;

  modport source (
    output valid, opcode, opcode_count, opcode_byte1, opcode_byte2, data_count,
           data_byte1, data_byte2, data_byte3, data_byte4, data_byte5,
    input  ready
  );

  modport sink (
    input  valid, opcode, opcode_count, opcode_byte1, opcode_byte2, data_count,
           data_byte1, data_byte2, data_byte3, data_byte4, data_byte5,
    output ready
  );
endinterface

// ===== hdl/srs1f_out_if.sv =====
// Text channel carrying one record character per transfer.
interface srs1f_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] text_char;
  logic       last;

  modport source (
    output valid, text_char, last,
    input  ready
  );

  modport sink (
    input  valid, text_char, last,
    output ready
  );
endinterface

// ===== hdl/srecord_s1_line_framer.sv =====
// A begin, an end, or a flush with buffered bytes leaves the idle step for its first text step,
// whose character is then registered; a spilling append first pushes bytes until the line is full.
// One character per step while emitting, unless the text channel holds off the transfer.
// A command is taken only when the sequencer sits at its idle step.
// Reset (async, active low) empties the line buffer, zeroes the address and start register.
module srecord_s1_line_framer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  srs1f_in_if.sink                     in_i,
  srs1f_out_if.source                  out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srs1f_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import srs1f_pkg::*;

  logic [15:0]      start_addr;
  logic [PcW-1:0]   pc_q, pc_d;
  ctrl_t            cw;
  logic [1:0]       op_q;
  logic [7:0]       ib_q [ItemBytes];
  logic [ItemW-1:0] total_q;
  logic [ItemW-1:0] pi_q;
  logic [7:0]       buf_q [LineBytes];
  logic [FillW-1:0] fill_q;
  logic [FillW-1:0] rd_idx_q;
  logic [15:0]      load_q;
  logic [7:0]       byt_q;
  logic [7:0]       sum_q;
  logic             ovalid_q;
  logic [6:0]       char_q;
  logic             last_q;
  logic             emits, go, more, full, push_done, accept, do_push;
  logic [1:0]       oc_sat;
  logic [2:0]       dc_sat;
  logic [6:0]       char_d;
  logic [7:0]       ib_d [ItemBytes];
  logic [7:0]       db [5];

  srs1f_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start_addr_o (start_addr)
  );

  // Fetch the control word of the current step
  assign cw        = srs1f_rom(pc_q);
  assign emits     = (cw.out_sel != OUT_NONE);
  assign go        = !emits || !ovalid_q || out_o.ready;
  assign more      = (rd_idx_q != fill_q);
  assign full      = (fill_q == FillW'(LineBytes));
  assign push_done = (pi_q == total_q);
  assign accept    = in_i.valid && (pc_q == PC_IDLE);
  assign do_push   = go && (cw.jmp == JMP_PUSH) && !push_done && !full;
  assign in_i.ready = (pc_q == PC_IDLE);

  // Saturate counts and pack the instruction bytes in push order
  assign oc_sat = (in_i.opcode_count > 2'd2) ? 2'd2 : in_i.opcode_count;
  assign dc_sat = (in_i.data_count > 3'd5) ? 3'd5 : in_i.data_count;
  assign db[0] = in_i.data_byte1;
  assign db[1] = in_i.data_byte2;
  assign db[2] = in_i.data_byte3;
  assign db[3] = in_i.data_byte4;
  assign db[4] = in_i.data_byte5;

  always_comb begin
    for (int k = 0; k < ItemBytes; k++) begin
      if (k == 0 && oc_sat != 2'd0) begin
        ib_d[k] = in_i.opcode_byte1;
      end else if (k == 1 && oc_sat == 2'd2) begin
        ib_d[k] = in_i.opcode_byte2;
      end else if ((k - int'(oc_sat)) >= 0 && (k - int'(oc_sat)) < 5) begin
        ib_d[k] = db[3'(k - int'(oc_sat))];
      end else begin
        ib_d[k] = 8'h00;
      end
    end
  end

  // Select the next step
  always_comb begin
    pc_d = pc_q;
    unique case (cw.jmp)
      JMP_NEXT: pc_d = pc_q + 1'b1;
      JMP_GOTO: pc_d = cw.target;
      JMP_MORE: pc_d = more ? cw.target : pc_q + 1'b1;
      JMP_DISPATCH: begin
        if (accept) begin
          unique case (in_i.opcode)
            OP_BEGIN, OP_END: pc_d = PC_TEXT;
            OP_APPEND:        pc_d = PC_PUSH;
            OP_FLUSH:         pc_d = (fill_q != '0) ? PC_LINE : PC_IDLE;
            default:          pc_d = PC_IDLE;
          endcase
        end
      end
      JMP_PUSH: begin
        if (push_done) begin
          pc_d = PC_IDLE;
        end else if (full) begin
          pc_d = PC_LINE;
        end
      end
      JMP_RET: pc_d = (op_q == OP_APPEND) ? PC_PUSH : PC_IDLE;
      default: pc_d = PC_IDLE;
    endcase
  end

  // Pick the emitted character
  always_comb begin
    case (cw.out_sel)
      OUT_CONST: char_d = cw.chr;
      OUT_TAG:   char_d = (op_q == OP_BEGIN) ? Ch0 : Ch9;
      OUT_HI:    char_d = hex_char(byt_q[7:4]);
      OUT_LO:    char_d = hex_char(byt_q[3:0]);
      default:   char_d = 7'h00;
    endcase
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else if (go) begin
      pc_q <= pc_d;
    end
  end

  // Latch a command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_BEGIN;
      total_q <= '0;
    end else if (accept) begin
      op_q    <= in_i.opcode;
      total_q <= ItemW'(oc_sat) + ItemW'(dc_sat);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < ItemBytes; k++) begin
        ib_q[k] <= ib_d[k];
      end
    end
  end

  // Track the push index, fill count and record address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pi_q   <= '0;
      fill_q <= '0;
      load_q <= '0;
    end else if (accept) begin
      pi_q <= '0;
      if (in_i.opcode == OP_BEGIN) begin
        fill_q <= '0;
        load_q <= start_addr;
      end
    end else if (do_push) begin
      pi_q   <= pi_q + 1'b1;
      fill_q <= fill_q + 1'b1;
    end else if (go && cw.line_end) begin
      fill_q <= '0;
      load_q <= load_q + 16'(fill_q);
    end
  end

  // Store a pushed byte into the line buffer
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[fill_q[IdxW-1:0]] <= ib_q[pi_q];
    end
  end

  // Load the byte register and accumulate the checksum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
    end else if (go && cw.ld_sel == LD_CNT) begin
      rd_idx_q <= '0;
    end else if (go && cw.ld_sel == LD_BUF_CSUM && more) begin
      rd_idx_q <= rd_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      case (cw.ld_sel)
        LD_CNT: begin
          byt_q <= 8'(fill_q) + 8'd3;
          sum_q <= 8'(fill_q) + 8'd3;
        end
        LD_AHI: begin
          byt_q <= load_q[15:8];
          sum_q <= sum_q + load_q[15:8];
        end
        LD_ALO: begin
          byt_q <= load_q[7:0];
          sum_q <= sum_q + load_q[7:0];
        end
        LD_BUF_CSUM: begin
          if (more) begin
            byt_q <= buf_q[rd_idx_q[IdxW-1:0]];
            sum_q <= sum_q + buf_q[rd_idx_q[IdxW-1:0]];
          end else begin
            byt_q <= ~sum_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the character until the downstream transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (go && emits) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emits) begin
      char_q <= char_d;
      last_q <= cw.last;
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.text_char = char_q;
  assign out_o.last      = last_q;

  // Checks on the sequencer
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(LineBytes))
    else $error("fill count beyond line size");

  // The read index is only meaningful once a line has restarted it
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q > PC_LINE) |-> (rd_idx_q <= fill_q))
    else $error("line read index passed fill count");

  a_line_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_LEND) |-> (fill_q != '0))
    else $error("empty S1 line closed");

  a_accept_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ovalid_q) |-> last_q)
    else $error("command taken while a record is still being emitted");
endmodule

// ===== hdl/srs1f_apb_regs.sv =====
// APB register file holding the start address of the first S1 record.
module srs1f_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srs1f_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [15:0]                 start_addr_o
);
  import srs1f_pkg::*;

  logic [15:0] start_q;
  logic        sel_start;

  // Decode the register index from the word address
  assign sel_start = (paddr[PaddrW-1] == RegStartAddr);

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (psel && penable && pwrite && sel_start) begin
      start_q <= pwdata[15:0];
    end
  end

  // Read back
  assign prdata       = sel_start ? {16'h0000, start_q} : 32'h0000_0000;
  assign pready       = 1'b1;
  assign start_addr_o = start_q;
endmodule

// ===== tb/sv/srs1f_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard of the S19 line framer: predicts the record text of each command and compares it.
module srs1f_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  srs1f_in_if                          cmd_i,
  srs1f_out_if                         text_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [srs1f_pkg::PaddrW-1:0] paddr_i,
  input  logic [31:0]                  pwdata_i,
  output int                           mismatch_count_o,
  output int                           pending_chars_o
);
  import srs1f_pkg::*;

  localparam logic [PaddrW-1:0] StartAddrOfs = {RegStartAddr, 2'b00};

  typedef struct packed {
    logic [6:0] text_char;
    logic       last;
  } text_beat_t;

  // Shadow of the framer state
  logic [7:0]  line_buf [LineBytes];
  int unsigned fill;
  logic [15:0] load_addr;
  logic [15:0] start_addr;
  int          mismatches;

  text_beat_t expected_text[$];
  text_beat_t cmd_text[$];

  function automatic logic [6:0] ascii_hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      return 7'h30 + 7'(v);
    end
    return 7'h41 + 7'(v - 4'd10);
  endfunction

  function automatic void emit_char(input logic [6:0] c);
    cmd_text.push_back('{text_char: c, last: 1'b0});
  endfunction

  function automatic void emit_hex(input logic [7:0] b);
    emit_char(ascii_hex_digit(b[7:4]));
    emit_char(ascii_hex_digit(b[3:0]));
  endfunction

  function automatic void emit_string(input string s);
    byte ch;
    for (int k = 0; k < s.len(); k++) begin
      ch = s[k];
      emit_char(ch[6:0]);
    end
  endfunction

  // Write out the buffered bytes as one S1 record, then advance the address
  function automatic void write_s1_line();
    logic [7:0] count_byte;
    logic [7:0] sum;
    count_byte = 8'(fill + 3);
    sum = count_byte + load_addr[15:8] + load_addr[7:0];
    emit_string("S1");
    emit_hex(count_byte);
    emit_hex(load_addr[15:8]);
    emit_hex(load_addr[7:0]);
    for (int k = 0; k < fill; k++) begin
      emit_hex(line_buf[k]);
      sum = sum + line_buf[k];
    end
    emit_hex(~sum);
    emit_char(7'h0A);
    load_addr = load_addr + 16'(fill);
    fill = 0;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    if (fill >= LineBytes) begin
      write_s1_line();
    end
    line_buf[fill] = b;
    fill++;
  endfunction

  // Predict the characters caused by the command now on the channel
  function automatic void frame_command();
    logic [7:0]  cmd_bytes [7];
    int unsigned n_op;
    int unsigned n_data;
    cmd_text.delete();
    cmd_bytes = '{cmd_i.opcode_byte1, cmd_i.opcode_byte2, cmd_i.data_byte1, cmd_i.data_byte2,
                  cmd_i.data_byte3, cmd_i.data_byte4, cmd_i.data_byte5};
    case (op_e'(cmd_i.opcode))
      OP_BEGIN: begin
        emit_string("S0030000FC\n");
        load_addr = start_addr;
        fill = 0;
      end
      OP_APPEND: begin
        // counts above the maximum saturate
        n_op = (cmd_i.opcode_count > 2'd2) ? 2 : cmd_i.opcode_count;
        n_data = (cmd_i.data_count > 3'd5) ? 5 : cmd_i.data_count;
        for (int k = 0; k < n_op; k++) begin
          push_byte(cmd_bytes[k]);
        end
        for (int k = 0; k < n_data; k++) begin
          push_byte(cmd_bytes[2 + k]);
        end
      end
      OP_FLUSH: begin
        if (fill != 0) begin
          write_s1_line();
        end
      end
      OP_END: begin
        emit_string("S9030000FC\n");
      end
      default: begin
      end
    endcase
    if (cmd_text.size() > 0) begin
      cmd_text[cmd_text.size() - 1].last = 1'b1;
    end
    foreach (cmd_text[k]) begin
      expected_text.push_back(cmd_text[k]);
    end
  endfunction

  // Track config writes, predict on command transfers, compare on text transfers
  always @(posedge clk_i or negedge rst_ni) begin : p_score
    text_beat_t head;
    if (!rst_ni) begin
      fill = 0;
      load_addr = '0;
      start_addr = '0;
      mismatches = 0;
      expected_text.delete();
      mismatch_count_o <= 0;
      pending_chars_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == StartAddrOfs) begin
        start_addr = pwdata_i[15:0];
      end
      if (cmd_i.valid && cmd_i.ready) begin
        frame_command();
      end
      if (text_i.valid && text_i.ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected transfer: text_char %h last %b", text_i.text_char, text_i.last);
          mismatches++;
        end else begin
          head = expected_text.pop_front();
          if (head.text_char !== text_i.text_char) begin
            $error("text_char: expected %h, got %h", head.text_char, text_i.text_char);
            mismatches++;
          end
          if (head.last !== text_i.last) begin
            $error("last: expected %b, got %b", head.last, text_i.last);
            mismatches++;
          end
        end
      end
      mismatch_count_o <= mismatches;
      pending_chars_o <= expected_text.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the S19 line framer test: clock, reset, command and config stimulus, verdict.
module testbench;
  import srs1f_pkg::*;

  localparam logic [PaddrW-1:0] StartAddrOfs  = {RegStartAddr, 2'b00};
  localparam logic [PaddrW-1:0] UnmappedOfs   = {~RegStartAddr, 2'b00};
  localparam int                DrainCycles   = 16;
  localparam int                QuietLimit    = 2000;
  localparam int                RandomPerPass = 52;

  typedef struct {
    op_e        op;
    logic [1:0] n_op;
    logic [7:0] op_bytes [2];
    logic [2:0] n_data;
    logic [7:0] data_bytes [5];
  } frame_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatch_count;
  int          pending_chars;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          quiet_cycles;

  srs1f_in_if  cmd_if ();
  srs1f_out_if text_if ();

  srecord_s1_line_framer u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (cmd_if),
    .out_o   (text_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  srs1f_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cmd_i            (cmd_if),
    .text_i           (text_if),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatch_count),
    .pending_chars_o  (pending_chars)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the text channel at random
  always @(posedge clk) begin
    text_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (cmd_if.valid && cmd_if.ready) || (text_if.valid && text_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic frame_cmd_t uniform_cmd(input op_e op, input logic [1:0] n_op,
                                             input logic [2:0] n_data, input logic [7:0] b);
    frame_cmd_t c;
    c.op = op;
    c.n_op = n_op;
    c.n_data = n_data;
    c.op_bytes = '{b, b};
    c.data_bytes = '{b, b, b, b, b};
    return c;
  endfunction

  // Mostly appends, so lines fill and spill; counts sometimes beyond their maximum
  function automatic frame_cmd_t random_cmd();
    frame_cmd_t  c;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      c.op = OP_BEGIN;
    end else if (pick < 84) begin
      c.op = OP_APPEND;
    end else if (pick < 93) begin
      c.op = OP_FLUSH;
    end else begin
      c.op = OP_END;
    end
    c.n_op = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
    c.n_data = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    foreach (c.op_bytes[k]) begin
      c.op_bytes[k] = 8'($urandom);
    end
    foreach (c.data_bytes[k]) begin
      c.data_bytes[k] = 8'($urandom);
    end
    return c;
  endfunction

  // Offer one command after a random gap and hold it until the transfer
  task automatic send_cmd(input frame_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.opcode       <= c.op;
    cmd_if.opcode_count <= c.n_op;
    cmd_if.opcode_byte1 <= c.op_bytes[0];
    cmd_if.opcode_byte2 <= c.op_bytes[1];
    cmd_if.data_count   <= c.n_data;
    cmd_if.data_byte1   <= c.data_bytes[0];
    cmd_if.data_byte2   <= c.data_bytes[1];
    cmd_if.data_byte3   <= c.data_bytes[2];
    cmd_if.data_byte4   <= c.data_bytes[3];
    cmd_if.data_byte5   <= c.data_bytes[4];
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  // Hold off commands until all predicted text has arrived and the block is idle
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (pending_chars != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PaddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [15:0] start_value;
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    cmd_if.valid        = 1'b0;
    cmd_if.opcode       = OP_BEGIN;
    cmd_if.opcode_count = '0;
    cmd_if.opcode_byte1 = '0;
    cmd_if.opcode_byte2 = '0;
    cmd_if.data_count   = '0;
    cmd_if.data_byte1   = '0;
    cmd_if.data_byte2   = '0;
    cmd_if.data_byte3   = '0;
    cmd_if.data_byte4   = '0;
    cmd_if.data_byte5   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty flush, trailer, saturated counts, full-line spill, discard on begin
    send_cmd(uniform_cmd(OP_FLUSH,  2'd0, 3'd0, 8'h00));
    send_cmd(uniform_cmd(OP_END,    2'd0, 3'd0, 8'h00));
    send_cmd(uniform_cmd(OP_APPEND, 2'd0, 3'd0, 8'hFF));
    send_cmd(uniform_cmd(OP_APPEND, 2'd3, 3'd7, 8'hFF));
    send_cmd(uniform_cmd(OP_APPEND, 2'd2, 3'd5, 8'h00));
    send_cmd(uniform_cmd(OP_APPEND, 2'd1, 3'd1, 8'hA5));
    send_cmd(uniform_cmd(OP_APPEND, 2'd1, 3'd0, 8'h5A));
    send_cmd(uniform_cmd(OP_FLUSH,  2'd0, 3'd0, 8'h00));
    send_cmd(uniform_cmd(OP_FLUSH,  2'd0, 3'd0, 8'h00));
    send_cmd(uniform_cmd(OP_APPEND, 2'd2, 3'd3, 8'h3C));
    send_cmd(uniform_cmd(OP_END,    2'd0, 3'd0, 8'h00));
    send_cmd(uniform_cmd(OP_FLUSH,  2'd0, 3'd0, 8'h00));
    send_cmd(uniform_cmd(OP_APPEND, 2'd2, 3'd5, 8'hC3));
    send_cmd(uniform_cmd(OP_BEGIN,  2'd0, 3'd0, 8'h00));
    send_cmd(uniform_cmd(OP_FLUSH,  2'd0, 3'd0, 8'h00));

    // Directed: top address, unmapped write ignored, address wrap after a full line
    wait_drained();
    apb_write(StartAddrOfs, 32'h0000_FFFF);
    apb_write(UnmappedOfs, 32'h0000_1234);
    send_cmd(uniform_cmd(OP_BEGIN,  2'd0, 3'd0, 8'h00));
    send_cmd(uniform_cmd(OP_APPEND, 2'd2, 3'd5, 8'h81));
    send_cmd(uniform_cmd(OP_APPEND, 2'd2, 3'd5, 8'h81));
    send_cmd(uniform_cmd(OP_APPEND, 2'd2, 3'd0, 8'h7E));
    send_cmd(uniform_cmd(OP_APPEND, 2'd0, 3'd1, 8'h01));
    send_cmd(uniform_cmd(OP_FLUSH,  2'd0, 3'd0, 8'h00));
    send_cmd(uniform_cmd(OP_END,    2'd0, 3'd0, 8'h00));

    // Random passes, one per idling mode, each with its own start address
    for (int pass = 0; pass < 4; pass++) begin
      wait_drained();
      case (pass)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          start_value = 16'h0000;
        end
        1: begin
          send_idle_pct = 69;
          recv_stall_pct = 0;
          start_value = 16'($urandom);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 69;
          start_value = 16'hFFFF;
        end
        default: begin
          send_idle_pct = 34;
          recv_stall_pct = 34;
          start_value = 16'hFFF0 | 16'($urandom_range(15));
        end
      endcase
      apb_write(StartAddrOfs, {16'($urandom), start_value});
      send_cmd(uniform_cmd(OP_BEGIN, 2'd0, 3'd0, 8'h00));
      for (int n = 0; n < RandomPerPass; n++) begin
        if ($urandom_range(29) == 0) begin
          wait_drained();
        end
        send_cmd(random_cmd());
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
